>>> hw/rtl/tdcm_pkg.sv
package tdcm_pkg;

  // configuration port
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CAL_W    = 12;

  // divider operand widths: |raw - ul| * pixels fits in 24 bits, |span| in 12
  localparam int unsigned NUM_W    = 24;
  localparam int unsigned DEN_W    = CAL_W;
  localparam int unsigned COORD_W  = 16;

  // register indexes
  localparam logic [2:0] REG_CAL_LEFT   = 3'd0;
  localparam logic [2:0] REG_CAL_TOP    = 3'd1;
  localparam logic [2:0] REG_CAL_RIGHT  = 3'd2;
  localparam logic [2:0] REG_CAL_BOTTOM = 3'd3;
  localparam logic [2:0] REG_WIDTH      = 3'd4;
  localparam logic [2:0] REG_HEIGHT     = 3'd5;
  localparam logic [2:0] REG_PRESS      = 3'd6;
  localparam logic [2:0] REG_RELEASE    = 3'd7;

  // reset values
  localparam logic [CAL_W-1:0] RST_CAL_UL     = 12'd3800;
  localparam logic [CAL_W-1:0] RST_CAL_LR     = 12'd275;
  localparam logic [CAL_W-1:0] RST_WIDTH      = 12'd320;
  localparam logic [CAL_W-1:0] RST_HEIGHT     = 12'd240;
  localparam logic [CAL_W-1:0] RST_PRESS      = 12'd400;
  localparam logic [CAL_W-1:0] RST_RELEASE    = 12'd75;

  typedef struct packed {
    logic [CAL_W-1:0] cal_left_raw;
    logic [CAL_W-1:0] cal_top_raw;
    logic [CAL_W-1:0] cal_right_raw;
    logic [CAL_W-1:0] cal_bottom_raw;
    logic [CAL_W-1:0] screen_width;
    logic [CAL_W-1:0] screen_height;
    logic [CAL_W-1:0] press_threshold;
    logic [CAL_W-1:0] release_threshold;
  } tdcm_cfg_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } tdcm_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [COORD_W-1:0] quot;
  } tdcm_div_rsp_t;

  typedef enum logic [2:0] {
    EV_UNCERTAIN = 3'd0,
    EV_NO_TOUCH  = 3'd1,
    EV_PRESENT   = 3'd2,
    EV_TOUCH     = 3'd3,
    EV_RELEASE   = 3'd4
  } tdcm_event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_DONE
  } tdcm_state_t;

endpackage

>>> hw/rtl/tdcm_cfg.sv
module tdcm_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdcm_pkg::ADDR_W-1:0]  paddr,
  input  logic [tdcm_pkg::DATA_W-1:0]  pwdata,
  output logic [tdcm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output tdcm_pkg::tdcm_cfg_t          cfg
);
  import tdcm_pkg::*;

  logic [2:0]       idx;
  logic             wr;
  logic [CAL_W-1:0] wdata;
  logic [CAL_W-1:0] rdata;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign wdata  = pwdata[CAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_left_raw      <= RST_CAL_UL;
      cfg.cal_top_raw       <= RST_CAL_UL;
      cfg.cal_right_raw     <= RST_CAL_LR;
      cfg.cal_bottom_raw    <= RST_CAL_LR;
      cfg.screen_width      <= RST_WIDTH;
      cfg.screen_height     <= RST_HEIGHT;
      cfg.press_threshold   <= RST_PRESS;
      cfg.release_threshold <= RST_RELEASE;
    end else if (wr) begin
      case (idx)
        REG_CAL_LEFT:   cfg.cal_left_raw      <= wdata;
        REG_CAL_TOP:    cfg.cal_top_raw       <= wdata;
        REG_CAL_RIGHT:  cfg.cal_right_raw     <= wdata;
        REG_CAL_BOTTOM: cfg.cal_bottom_raw    <= wdata;
        REG_WIDTH:      cfg.screen_width      <= wdata;
        REG_HEIGHT:     cfg.screen_height     <= wdata;
        REG_PRESS:      cfg.press_threshold   <= wdata;
        REG_RELEASE:    cfg.release_threshold <= wdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAL_LEFT:   rdata = cfg.cal_left_raw;
      REG_CAL_TOP:    rdata = cfg.cal_top_raw;
      REG_CAL_RIGHT:  rdata = cfg.cal_right_raw;
      REG_CAL_BOTTOM: rdata = cfg.cal_bottom_raw;
      REG_WIDTH:      rdata = cfg.screen_width;
      REG_HEIGHT:     rdata = cfg.screen_height;
      REG_PRESS:      rdata = cfg.press_threshold;
      REG_RELEASE:    rdata = cfg.release_threshold;
      default:        rdata = '0;
    endcase
  end

  assign prdata = {{(DATA_W-CAL_W){1'b0}}, rdata};

endmodule

>>> hw/rtl/tdcm_div.sv
module tdcm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  tdcm_pkg::tdcm_div_req_t req,
  output tdcm_pkg::tdcm_div_rsp_t rsp
);
  import tdcm_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [NUM_W-1:0] signed_q;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      neg <= req.neg;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      num <= {num[NUM_W-2:0], fits};
    end
  end

  // quotient is held in num once the last step is done
  assign signed_q = neg ? (~num + 1'b1) : num;

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = signed_q[COORD_W-1:0];

endmodule

>>> hw/rtl/touch_debounce_coordinate_map_unit.sv
// channel   direction  handshake              payload
// in        to block   in_valid / in_stall    raw_x, raw_y, raw_pressure, now_ms
// out       from block out_valid / out_stall  screen_x, screen_y, pressure_out,
//                                             raw_x_out, raw_y_out, event_code
// cfg       to block   apb psel/penable       paddr, pwdata, prdata
//
// each axis of a word passes in turn through the multiply state, the load state and
// the shared 24-step radix-2 divider.
// in_stall is high from acceptance until the result is loaded into the output
// register; a result waiting on out_stall lets the next word be accepted.
// rst is synchronous: it clears the sequencer, the touch flag, the debounce
// start time, out_valid and the registers to their defaults.
module touch_debounce_coordinate_map_unit #(
  parameter int unsigned DEBOUNCE_TIME = 50
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdcm_pkg::ADDR_W-1:0]  paddr,
  input  logic [tdcm_pkg::DATA_W-1:0]  pwdata,
  output logic [tdcm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [11:0]                  raw_x,
  input  logic [11:0]                  raw_y,
  input  logic [11:0]                  raw_pressure,
  input  logic [31:0]                  now_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           screen_x,
  output logic signed [15:0]           screen_y,
  output logic [11:0]                  pressure_out,
  output logic [11:0]                  raw_x_out,
  output logic [11:0]                  raw_y_out,
  output logic [2:0]                   event_code
);
  import tdcm_pkg::*;

  tdcm_cfg_t      cfg;
  tdcm_div_req_t  div_req;
  tdcm_div_rsp_t  div_rsp;
  tdcm_state_t    state;
  tdcm_state_t    state_next;

  logic           accept;
  logic           div_start;
  logic           load_out;
  logic           axis;

  // latched word
  logic [CAL_W-1:0] rx;
  logic [CAL_W-1:0] ry;
  logic [CAL_W-1:0] pres;
  tdcm_event_t      code;

  // mapping datapath
  logic [CAL_W-1:0]       m_raw;
  logic [CAL_W-1:0]       m_ul;
  logic [CAL_W-1:0]       m_lr;
  logic [CAL_W-1:0]       m_pix;
  logic signed [CAL_W:0]  diff;
  logic signed [CAL_W:0]  span_c;
  logic signed [2*CAL_W+1:0] mul_full;
  logic signed [NUM_W:0]  prod;
  logic signed [CAL_W:0]  span;
  logic [NUM_W:0]         prod_abs;
  logic [CAL_W:0]         span_abs;
  logic [COORD_W-1:0]     sx;
  logic [COORD_W-1:0]     sy;
  logic [COORD_W-1:0]     coord;

  // debounce
  logic        touching;
  logic [31:0] debounce_start;
  logic        cls;
  tdcm_event_t cls_code;
  logic [31:0] elapsed;

  tdcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdcm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) state_next = axis ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pressure class with hysteresis, press test first
  always_comb begin
    cls      = touching;
    cls_code = EV_UNCERTAIN;
    if (raw_pressure >= cfg.press_threshold) begin
      cls      = 1'b1;
      cls_code = EV_PRESENT;
    end else if (raw_pressure <= cfg.release_threshold) begin
      cls      = 1'b0;
      cls_code = EV_NO_TOUCH;
    end
  end

  assign elapsed = now_ms - debounce_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      touching       <= 1'b0;
      debounce_start <= '0;
      axis           <= 1'b0;
    end else begin
      if (accept) begin
        axis <= 1'b0;
        if (cls == touching) begin
          debounce_start <= now_ms;
        end else if (elapsed >= 32'(DEBOUNCE_TIME)) begin
          debounce_start <= now_ms;
          touching       <= cls;
        end
      end else if (state == S_DIV && div_rsp.done) begin
        axis <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rx   <= raw_x;
      ry   <= raw_y;
      pres <= raw_pressure;
      if (cls != touching && elapsed >= 32'(DEBOUNCE_TIME)) begin
        code <= cls ? EV_TOUCH : EV_RELEASE;
      end else begin
        code <= cls_code;
      end
    end
  end

  // operands of the current axis
  assign m_raw  = axis ? ry : rx;
  assign m_ul   = axis ? cfg.cal_top_raw : cfg.cal_left_raw;
  assign m_lr   = axis ? cfg.cal_bottom_raw : cfg.cal_right_raw;
  assign m_pix  = axis ? cfg.screen_height : cfg.screen_width;
  assign diff   = $signed({1'b0, m_raw}) - $signed({1'b0, m_ul});
  assign span_c = $signed({1'b0, m_lr}) - $signed({1'b0, m_ul});
  assign mul_full = diff * $signed({1'b0, m_pix});

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= mul_full[NUM_W:0];
      span <= span_c;
    end
  end

  assign prod_abs = prod[NUM_W] ? (~prod + 1'b1) : prod;
  assign span_abs = span[CAL_W] ? (~span + 1'b1) : span;

  assign div_req.start = div_start;
  assign div_req.neg   = prod[NUM_W] ^ span[CAL_W];
  assign div_req.num   = prod_abs[NUM_W-1:0];
  assign div_req.den   = span_abs[DEN_W-1:0];

  // zero span maps to zero
  assign coord = (span == '0) ? '0 : div_rsp.quot;

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done) begin
      if (axis) begin
        sy <= coord;
      end else begin
        sx <= coord;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      screen_x     <= sx;
      screen_y     <= sy;
      pressure_out <= pres;
      raw_x_out    <= rx;
      raw_y_out    <= ry;
      event_code   <= code;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_x: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL) && !axis)
    else $error("accepted word did not start the x axis");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV) && !div_rsp.busy)
    else $error("divider finished outside the divide step");

  a_touch_only_on_word: assert property (@(posedge clk) disable iff (rst)
    (touching != $past(touching)) |-> $past(accept))
    else $error("touch flag changed without an accepted word");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load_out)
    else $error("output register overwritten while stalled");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tdcm_pkg::*;

  localparam int DEBOUNCE_MS    = 50;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {
    PRESS_ABSENT,
    PRESS_PRESENT,
    PRESS_UNSURE
  } press_kind_t;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [11:0]        pres;
    logic [11:0]        rx;
    logic [11:0]        ry;
    tdcm_event_t        ev;
  } touch_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [11:0]         raw_x = '0;
  logic [11:0]         raw_y = '0;
  logic [11:0]         raw_pressure = '0;
  logic [31:0]         now_ms = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [15:0]  screen_x;
  logic signed [15:0]  screen_y;
  logic [11:0]         pressure_out;
  logic [11:0]         raw_x_out;
  logic [11:0]         raw_y_out;
  logic [2:0]          event_code;

  // shadow of the calibration registers and of the debounce state
  logic [11:0]   cal_reg [8];
  logic          held_touch;
  logic [31:0]   bounce_start;
  touch_result_t expected_results [$];
  touch_result_t want;

  logic [31:0] stamp_ms;
  logic        no_idle = 1'b0;
  int          err_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          touch_count = 0;
  int          release_count = 0;
  int          setting_count = 0;
  int          idle_cycles = 0;

  touch_debounce_coordinate_map_unit #(
    .DEBOUNCE_TIME(DEBOUNCE_MS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_pressure (raw_pressure),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .pressure_out (pressure_out),
    .raw_x_out    (raw_x_out),
    .raw_y_out    (raw_y_out),
    .event_code   (event_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_error(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endfunction

  // (raw - ul) * pixels / (lr - ul), truncated toward zero, kept to 16 bits
  function automatic logic [15:0] map_axis(input logic [11:0] raw, ul, lr, pix);
    longint span;
    longint q;
    span = longint'(lr) - longint'(ul);
    if (span == 0) return 16'd0;
    q = ((longint'(raw) - longint'(ul)) * longint'(pix)) / span;
    return q[15:0];
  endfunction

  function automatic touch_result_t predict_sample(input logic [11:0] x, y, p,
                                                   input logic [31:0] t);
    touch_result_t r;
    logic          cls;
    logic [31:0]   age;
    r.sx   = map_axis(x, cal_reg[REG_CAL_LEFT], cal_reg[REG_CAL_RIGHT], cal_reg[REG_WIDTH]);
    r.sy   = map_axis(y, cal_reg[REG_CAL_TOP], cal_reg[REG_CAL_BOTTOM], cal_reg[REG_HEIGHT]);
    r.pres = p;
    r.rx   = x;
    r.ry   = y;
    r.ev   = EV_UNCERTAIN;
    cls    = held_touch;
    // press test wins when the thresholds overlap
    if (p >= cal_reg[REG_PRESS]) begin
      cls  = 1'b1;
      r.ev = EV_PRESENT;
    end else if (p <= cal_reg[REG_RELEASE]) begin
      cls  = 1'b0;
      r.ev = EV_NO_TOUCH;
    end
    age = t - bounce_start;
    if (cls == held_touch) begin
      bounce_start = t;
    end else if (age >= DEBOUNCE_MS) begin
      bounce_start = t;
      held_touch   = cls;
      r.ev         = cls ? EV_TOUCH : EV_RELEASE;
    end
    return r;
  endfunction

  function automatic logic [11:0] pick_pressure(input press_kind_t kind);
    int press;
    int rel;
    press = int'(cal_reg[REG_PRESS]);
    rel   = int'(cal_reg[REG_RELEASE]);
    case (kind)
      PRESS_PRESENT: return 12'($urandom_range(4095, press));
      PRESS_ABSENT:  return 12'($urandom_range(rel, 0));
      default: begin
        if (press > rel + 1) return 12'($urandom_range(press - 1, rel + 1));
        return 12'($urandom_range(4095, 0));
      end
    endcase
  endfunction

  function automatic logic [11:0] rand_cal();
    case ($urandom_range(7))
      0:       return 12'd0;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // output side: random stall, off during the no-idle stretch
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_error("result word with no sample pending");
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (screen_x !== want.sx || screen_y !== want.sy || pressure_out !== want.pres ||
            raw_x_out !== want.rx || raw_y_out !== want.ry || event_code !== want.ev) begin
          note_error($sformatf({"exp x=%0d y=%0d p=%0d rx=%0d ry=%0d ev=%0d, ",
                                "got x=%0d y=%0d p=%0d rx=%0d ry=%0d ev=%0d"},
                               want.sx, want.sy, want.pres, want.rx, want.ry, want.ev,
                               screen_x, screen_y, pressure_out, raw_x_out, raw_y_out,
                               event_code));
        end
        if (want.ev == EV_TOUCH) touch_count++;
        if (want.ev == EV_RELEASE) release_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic apb_access(input logic [2:0] idx, input logic wr,
                            input logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [11:0] exp_val);
    logic [31:0] rd;
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== {20'd0, exp_val})
      note_error($sformatf("register %0d reads %0h, exp %0h", idx, rd, exp_val));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    logic [31:0] data;
    logic [31:0] rd;
    // upper bits are junk, only the low 12 are kept
    data       = $urandom();
    data[11:0] = val;
    apb_access(idx, 1'b1, data, rd);
    cal_reg[idx] = val;
    check_reg(idx, val);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_calibration(input logic [11:0] left, top, right, bottom,
                                 input logic [11:0] width, height, press, rel);
    wait_results_done();
    write_reg(REG_CAL_LEFT, left);
    write_reg(REG_CAL_TOP, top);
    write_reg(REG_CAL_RIGHT, right);
    write_reg(REG_CAL_BOTTOM, bottom);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    write_reg(REG_PRESS, press);
    write_reg(REG_RELEASE, rel);
    setting_count++;
  endtask

  task automatic send_sample(input logic [11:0] x, y, p, input logic [31:0] t);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    raw_x        <= x;
    raw_y        <= y;
    raw_pressure <= p;
    now_ms       <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_sample(x, y, p, t));
    sent_count++;
  endtask

  // strokes of steady pressure class with small time steps, plus glitches and noise
  task automatic send_strokes(input int n);
    int          sent;
    int          len;
    press_kind_t cls;
    logic [11:0] p;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        len = $urandom_range(12, 1);
        cls = press_kind_t'($urandom_range(2));
        for (int i = 0; i < len && sent < n; i++) begin
          stamp_ms += $urandom_range(40);
          if ($urandom_range(7) == 0) p = pick_pressure(press_kind_t'($urandom_range(2)));
          else p = pick_pressure(cls);
          send_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)), p, stamp_ms);
          sent++;
        end
      end else begin
        if ($urandom_range(3) == 0) stamp_ms = $urandom();
        else stamp_ms += $urandom_range(200);
        send_sample(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                    12'($urandom_range(4095)), stamp_ms);
        sent++;
      end
    end
  endtask

  task automatic test_reset_values();
    check_reg(REG_CAL_LEFT, RST_CAL_UL);
    check_reg(REG_CAL_TOP, RST_CAL_UL);
    check_reg(REG_CAL_RIGHT, RST_CAL_LR);
    check_reg(REG_CAL_BOTTOM, RST_CAL_LR);
    check_reg(REG_WIDTH, RST_WIDTH);
    check_reg(REG_HEIGHT, RST_HEIGHT);
    check_reg(REG_PRESS, RST_PRESS);
    check_reg(REG_RELEASE, RST_RELEASE);
  endtask

  // threshold edges, debounce too young / just old enough, 32-bit time wrap
  task automatic test_debounce_edges();
    send_sample(12'd0,    12'd0,    12'd0,    32'd0);
    send_sample(12'hFFF,  12'hFFF,  12'hFFF,  32'd10);
    send_sample(12'd275,  12'd3800, 12'd400,  32'd49);
    send_sample(12'd3800, 12'd275,  12'd400,  32'd50);
    send_sample(12'd2048, 12'd1024, 12'd200,  32'd1000);
    send_sample(12'h555,  12'hAAA,  12'd75,   32'd1020);
    send_sample(12'hAAA,  12'h555,  12'd76,   32'd1100);
    send_sample(12'd1,    12'd4094, 12'd0,    32'd1149);
    send_sample(12'd4094, 12'd1,    12'd0,    32'd1150);
    send_sample(12'd100,  12'd200,  12'd399,  32'hFFFF_FFF0);
    send_sample(12'd300,  12'd400,  12'hFFF,  32'hFFFF_FFF1);
    send_sample(12'd500,  12'd600,  12'd0,    32'h0000_0010);
    send_sample(12'd700,  12'd800,  12'd0,    32'h0000_0022);
  endtask

  // zero spans, zero and full pixel counts, 16-bit wrap, overlapping thresholds
  task automatic test_map_extremes();
    set_calibration(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_sample(12'hFFF, 12'd0, 12'd0, 32'd5000);
    send_sample(12'd0, 12'hFFF, 12'hFFF, 32'd5100);
    set_calibration(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_sample(12'd0, 12'hFFF, 12'hFFF, 32'd5200);
    send_sample(12'hFFF, 12'd0, 12'd0, 32'd5300);
    set_calibration(12'd0, 12'hFFF, 12'd1, 12'hFFE, 12'hFFF, 12'hFFF, 12'd100, 12'd200);
    send_sample(12'hFFF, 12'd0, 12'd150, 32'd5400);
    send_sample(12'd0, 12'hFFF, 12'd100, 32'd5401);
    send_sample(12'd2048, 12'd2048, 12'd200, 32'd5500);
    send_sample(12'd1, 12'hFFE, 12'd99, 32'd5600);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    logic [11:0] a;
    logic [11:0] b;
    for (int ph = 0; ph < phases; ph++) begin
      a = rand_cal();
      b = rand_cal();
      // mostly a real hysteresis band, sometimes overlapping
      if ($urandom_range(5) == 0)
        set_calibration(rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal(),
                        rand_cal(), (a < b) ? a : b, (a < b) ? b : a);
      else
        set_calibration(rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal(),
                        rand_cal(), (a < b) ? b : a, (a < b) ? a : b);
      if ($urandom_range(2) == 0) stamp_ms = 32'hFFFF_FF80;
      send_strokes(per_phase);
    end
  endtask

  task automatic test_back_to_back();
    set_calibration(RST_CAL_UL, RST_CAL_UL, RST_CAL_LR, RST_CAL_LR, RST_WIDTH, RST_HEIGHT,
                    RST_PRESS, RST_RELEASE);
    no_idle <= 1'b1;
    send_strokes(60);
    no_idle <= 1'b0;
  endtask

  task automatic test_drain_pause();
    send_strokes(20);
    wait_results_done();
    send_strokes(20);
  endtask

  initial begin
    cal_reg[REG_CAL_LEFT]   = RST_CAL_UL;
    cal_reg[REG_CAL_TOP]    = RST_CAL_UL;
    cal_reg[REG_CAL_RIGHT]  = RST_CAL_LR;
    cal_reg[REG_CAL_BOTTOM] = RST_CAL_LR;
    cal_reg[REG_WIDTH]      = RST_WIDTH;
    cal_reg[REG_HEIGHT]     = RST_HEIGHT;
    cal_reg[REG_PRESS]      = RST_PRESS;
    cal_reg[REG_RELEASE]    = RST_RELEASE;
    held_touch   = 1'b0;
    bounce_start = 32'd0;
    stamp_ms     = 32'd6000;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_debounce_edges();
    test_map_extremes();
    test_random_settings(8, 80);
    test_back_to_back();
    test_drain_pause();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d touch samples over %0d calibration settings, %0d results checked",
             sent_count, setting_count, checked_count);
    $display("debounce produced %0d touch and %0d release events, %0d errors",
             touch_count, release_count, err_count);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tdcm_pkg.sv
hw/rtl/tdcm_cfg.sv
hw/rtl/tdcm_div.sv
hw/rtl/touch_debounce_coordinate_map_unit.sv
tb/sv/tb.sv
